// File: rtl/core/button_toggle_trim_counter_defines.svh
// assertion macros for the button toggle trim counter rtl
// no dependencies; included by button_toggle_trim_counter, the only module that carries assertions
`ifndef BUTTON_TOGGLE_TRIM_COUNTER_DEFINES_SVH
`define BUTTON_TOGGLE_TRIM_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, quiet while reset is asserted
`define BTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("btc assertion failed");

// next-cycle implication, quiet while reset is asserted
`define BTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("btc assertion failed");

`else

`define BTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/btc_pkg.sv
// types, widths and register indexes of the button toggle trim counter
// no dependencies; imported by every module of the block
package btc_pkg;

	localparam int TRIM_BITS   = 16;
	localparam int PERIOD_BITS = 16;
	localparam int COUNT_BITS  = PERIOD_BITS + 1;
	localparam int CFG_DATA_BITS = (TRIM_BITS > PERIOD_BITS) ? TRIM_BITS : PERIOD_BITS;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_DELAY    = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_PERIOD = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_TRIM_MIN      = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_TRIM_MAX      = CFG_IDX_BITS'(3);

	localparam logic [PERIOD_BITS-1:0] HOLD_DELAY_RST    = PERIOD_BITS'(1000);
	localparam logic [PERIOD_BITS-1:0] REPEAT_PERIOD_RST = PERIOD_BITS'(100);

	typedef struct packed {
		logic button_one;
		logic button_two;
	} item_t;

	typedef struct packed {
		logic                        toggle_one;
		logic                        toggle_two;
		logic                        toggle_both;
		logic signed [TRIM_BITS-1:0] trim_value;
		logic                        auto_repeat_on;
	} result_t;

	typedef struct packed {
		logic        [PERIOD_BITS-1:0] hold_delay_period;
		logic        [PERIOD_BITS-1:0] repeat_period;
		logic signed [TRIM_BITS-1:0]   trim_min;
		logic signed [TRIM_BITS-1:0]   trim_max;
	} cfg_t;

	typedef struct packed {
		logic                        prev_one;
		logic                        prev_two;
		logic [2:0]                  toggles;
		logic                        auto_mode;
		logic [COUNT_BITS-1:0]       hold_count;
		logic [COUNT_BITS-1:0]       repeat_count;
		logic signed [TRIM_BITS-1:0] trim;
	} state_t;

endpackage

// File: rtl/core/button_toggle_trim_counter.sv
// top level of the button toggle trim counter: input register, tick state,
// result register; depends on btc_pkg, btc_cfg, btc_step and the defines header
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_ready     btc_pkg::item_t
//  result    out        result_valid / result_ready btc_pkg::result_t
//  cfg       in         cfg_we (no wait)            cfg_addr, cfg_wdata
//
// one item per cycle unless the result stalls; result_valid follows the result register
// the tick state updates as an item moves from the item register to the result register
// arst_n clears tick state, valids and config registers to their reset values
// a stalled result holds the item register, which then holds item_ready low
`include "button_toggle_trim_counter_defines.svh"

module button_toggle_trim_counter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  btc_pkg::item_t                    item,
	output logic                              result_valid,
	input  logic                              result_ready,
	output btc_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [btc_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
	input  logic [btc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import btc_pkg::*;

	cfg_t    cfg;
	state_t  st_q, st_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;

	btc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	btc_step u_step (
		.item    (item_s1),
		.st      (st_q),
		.cfg     (cfg),
		.st_next (st_next)
	);

	assign advance    = valid_s1 & (~valid_s2 | result_ready);
	assign item_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.toggle_one     <= st_next.toggles[0];
			result_s2.toggle_two     <= st_next.toggles[1];
			result_s2.toggle_both    <= st_next.toggles[2];
			result_s2.trim_value     <= st_next.trim;
			result_s2.auto_repeat_on <= st_next.auto_mode;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// a transfer out of the item register always lands in the result register
	`BTC_ASSERT_NXT(a_advance_fills, clk, arst_n, advance, valid_s2)
	// auto-repeat is only reached after the hold counter has run
	`BTC_ASSERT_IMP(a_auto_has_hold, clk, arst_n, st_q.auto_mode, st_q.hold_count != '0)
	// with a sane range the next trim never leaves it
	`BTC_ASSERT_IMP(a_trim_in_range, clk, arst_n,
		advance && ($signed(cfg.trim_min) <= $signed(cfg.trim_max)),
		($signed(st_next.trim) <= $signed(cfg.trim_max)) && ($signed(st_next.trim) >= $signed(cfg.trim_min)))

endmodule

// File: rtl/core/btc_cfg.sv
// configuration register file of the button toggle trim counter
// depends on btc_pkg
module btc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [btc_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
	input  logic [btc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	output btc_pkg::cfg_t                     cfg
);
	import btc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_delay_period <= HOLD_DELAY_RST;
			cfg_q.repeat_period     <= REPEAT_PERIOD_RST;
			cfg_q.trim_min          <= {1'b1, {(TRIM_BITS-1){1'b0}}};
			cfg_q.trim_max          <= {1'b0, {(TRIM_BITS-1){1'b1}}};
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HOLD_DELAY:    cfg_q.hold_delay_period <= cfg_wdata[PERIOD_BITS-1:0];
				REG_REPEAT_PERIOD: cfg_q.repeat_period     <= cfg_wdata[PERIOD_BITS-1:0];
				REG_TRIM_MIN:      cfg_q.trim_min          <= cfg_wdata[TRIM_BITS-1:0];
				REG_TRIM_MAX:      cfg_q.trim_max          <= cfg_wdata[TRIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/btc_step.sv
// next-state logic for one tick: edge detect, toggles, hold and repeat
// counters, trim step and clamp; depends on btc_pkg
module btc_step (
	input  btc_pkg::item_t  item,
	input  btc_pkg::state_t st,
	input  btc_pkg::cfg_t   cfg,
	output btc_pkg::state_t st_next
);
	import btc_pkg::*;

	logic                   e1, e2, e12, single;
	logic [COUNT_BITS-1:0]  hold_inc, rep_inc;
	logic                   auto_n, fire, step_up, step_dn;
	logic signed [TRIM_BITS:0] v, lo, hi, v_max, v_clamp;

	always_comb begin
		e1  = item.button_one & ~st.prev_one;
		e2  = item.button_two & ~st.prev_two;
		e12 = item.button_one & item.button_two & ~(st.prev_one & st.prev_two);
		single = item.button_one ^ item.button_two;

		// hold counter only runs until auto-repeat is reached, saturating
		hold_inc = (!st.auto_mode && st.hold_count != '1) ? st.hold_count + 1'b1
			: st.hold_count;

		st_next.prev_one = item.button_one;
		st_next.prev_two = item.button_two;
		st_next.toggles  = st.toggles ^ {e12, e2, e1};

		if (single) begin
			st_next.hold_count = hold_inc;
			auto_n = st.auto_mode | (hold_inc > {1'b0, cfg.hold_delay_period});
		end else begin
			st_next.hold_count = '0;
			auto_n = 1'b0;
		end
		st_next.auto_mode = auto_n;

		rep_inc = (st.repeat_count != '1) ? st.repeat_count + 1'b1 : st.repeat_count;
		fire    = rep_inc > {1'b0, cfg.repeat_period};

		// repeat count is kept as is when auto-repeat drops
		if (auto_n) begin
			st_next.repeat_count = fire ? '0 : rep_inc;
			step_up = fire & item.button_two;
			step_dn = fire & item.button_one;
		end else begin
			st_next.repeat_count = st.repeat_count;
			step_up = e2;
			step_dn = e1;
		end

		v = {st.trim[TRIM_BITS-1], st.trim}
			+ {{TRIM_BITS{1'b0}}, step_up} - {{TRIM_BITS{1'b0}}, step_dn};
		hi = {cfg.trim_max[TRIM_BITS-1], cfg.trim_max};
		lo = {cfg.trim_min[TRIM_BITS-1], cfg.trim_min};

		// max clamp first, min clamp wins
		v_max   = (v > hi) ? hi : v;
		v_clamp = (v_max < lo) ? lo : v_max;
		st_next.trim = v_clamp[TRIM_BITS-1:0];
	end

endmodule

// File: dv/tb_button_toggle_trim_counter.sv
// self-checking testbench for button_toggle_trim_counter: drives debounced button
// ticks, predicts toggles, trim and auto-repeat, and checks every result transfer
// depends on btc_pkg and the button_toggle_trim_counter rtl
`timescale 1ns / 100ps

module tb_button_toggle_trim_counter;
	import btc_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(6);

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_addr = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	button_toggle_trim_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	// predictor copy of the registers
	logic [PERIOD_BITS-1:0] hold_delay = HOLD_DELAY_RST;
	logic [PERIOD_BITS-1:0] rep_period = REPEAT_PERIOD_RST;
	logic signed [TRIM_BITS-1:0] trim_lo = {1'b1, {(TRIM_BITS-1){1'b0}}};
	logic signed [TRIM_BITS-1:0] trim_hi = {1'b0, {(TRIM_BITS-1){1'b1}}};

	// predictor copy of the tick state
	logic last_one = 1'b0;
	logic last_two = 1'b0;
	logic [2:0] toggles = '0;
	logic auto_on = 1'b0;
	logic [COUNT_BITS-1:0] hold_ticks = '0;
	logic [COUNT_BITS-1:0] repeat_ticks = '0;
	logic signed [TRIM_BITS-1:0] trim_now = '0;

	item_t button_ticks[$];
	result_t predicted_ticks[$];
	bit item_sent = 1'b0;
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_phase = 0;

	function automatic result_t trim_tick(item_t it);
		logic b1, b2, e1, e2, e12;
		int v;
		result_t r;
		b1 = it.button_one;
		b2 = it.button_two;
		e1 = b1 & ~last_one;
		e2 = b2 & ~last_two;
		e12 = b1 & b2 & ~(last_one & last_two);
		toggles ^= {e12, e2, e1};
		last_one = b1;
		last_two = b2;
		v = trim_now;
		if (b1 ^ b2) begin
			if (!auto_on && hold_ticks != '1)
				hold_ticks++;
			if (hold_ticks > hold_delay)
				auto_on = 1'b1;
		end else begin
			// repeat count survives leaving auto-repeat
			hold_ticks = '0;
			auto_on = 1'b0;
		end
		if (auto_on) begin
			if (repeat_ticks != '1)
				repeat_ticks++;
			if (repeat_ticks > rep_period) begin
				repeat_ticks = '0;
				if (b2) v++;
				if (b1) v--;
			end
		end else begin
			if (e2) v++;
			if (e1) v--;
		end
		// max first, min last, so min wins when above max
		if (v > trim_hi) v = trim_hi;
		if (v < trim_lo) v = trim_lo;
		trim_now = TRIM_BITS'(v);
		r.toggle_one = toggles[0];
		r.toggle_two = toggles[1];
		r.toggle_both = toggles[2];
		r.trim_value = trim_now;
		r.auto_repeat_on = auto_on;
		return r;
	endfunction

	function automatic int fit_trim(int v);
		if (v < -(1 << (TRIM_BITS-1))) return -(1 << (TRIM_BITS-1));
		if (v > (1 << (TRIM_BITS-1)) - 1) return (1 << (TRIM_BITS-1)) - 1;
		return v;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HOLD_DELAY: hold_delay = data[PERIOD_BITS-1:0];
			REG_REPEAT_PERIOD: rep_period = data[PERIOD_BITS-1:0];
			REG_TRIM_MIN: trim_lo = data[TRIM_BITS-1:0];
			REG_TRIM_MAX: trim_hi = data[TRIM_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic push_tick(input logic b1, input logic b2, input int n);
		item_t t;
		t.button_one = b1;
		t.button_two = b2;
		repeat (n) button_ticks.push_back(t);
	endtask

	// wait for every queued tick to be checked, then let the pipeline settle
	task automatic run_ticks();
		@(posedge clk);
		while (button_ticks.size() != 0 || predicted_ticks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic shuffle_settings();
		int lo, hi;
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 7))
				0: write_reg(REG_HOLD_DELAY, '1);
				1: write_reg(REG_HOLD_DELAY, HOLD_DELAY_RST);
				default: write_reg(REG_HOLD_DELAY, CFG_DATA_BITS'($urandom_range(0, 12)));
			endcase
		end
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 7))
				0: write_reg(REG_REPEAT_PERIOD, '1);
				1, 2: write_reg(REG_REPEAT_PERIOD, '0);
				default: write_reg(REG_REPEAT_PERIOD, CFG_DATA_BITS'($urandom_range(1, 6)));
			endcase
		end
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 5))
				0: begin
					lo = -(1 << (TRIM_BITS-1));
					hi = (1 << (TRIM_BITS-1)) - 1;
				end
				1: begin
					// minimum above maximum
					lo = int'(trim_now) + $urandom_range(1, 4);
					hi = int'(trim_now) - $urandom_range(0, 3);
				end
				default: begin
					lo = int'(trim_now) - $urandom_range(0, 8);
					hi = int'(trim_now) + $urandom_range(0, 8);
				end
			endcase
			lo = fit_trim(lo);
			hi = fit_trim(hi);
			if ($urandom_range(0, 1)) begin
				write_reg(REG_TRIM_MIN, CFG_DATA_BITS'(lo));
				write_reg(REG_TRIM_MAX, CFG_DATA_BITS'(hi));
			end else begin
				write_reg(REG_TRIM_MAX, CFG_DATA_BITS'(hi));
				write_reg(REG_TRIM_MIN, CFG_DATA_BITS'(lo));
			end
		end
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
	endtask

	// mostly single-button holds sized around the hold delay and repeat period, plus chords, handovers and noise
	task automatic queue_random_ticks(input int n);
		int len, len2, k;
		logic b;
		while (button_ticks.size() < n) begin
			k = $urandom_range(0, 9);
			b = 1'($urandom_range(0, 1));
			len = hold_delay + (rep_period + 1) * $urandom_range(0, 4) + $urandom_range(0, 2);
			if (len > 60 || len < 1)
				len = $urandom_range(1, 60);
			if (k < 5) begin
				push_tick(b, !b, len);
				push_tick(1'b0, 1'b0, $urandom_range(0, 2));
			end else if (k < 7) begin
				push_tick(b, !b, $urandom_range(0, 3));
				push_tick(1'b1, 1'b1, $urandom_range(1, 4));
			end else if (k == 7) begin
				// hand over from one button to the other without a release
				len2 = $urandom_range(1, 20);
				push_tick(b, !b, len);
				push_tick(!b, b, len2);
			end else begin
				repeat ($urandom_range(1, 8))
					push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_sent)) begin
			item_sent = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (button_ticks.size() != 0) begin
				item_valid <= 1'b1;
				item <= button_ticks[0];
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: stall mode is redrawn whenever stall_left runs down to zero
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 300);
		end else begin
			stall_left--;
		end
		stall_phase = (stall_phase + 1) % 5;
		case (stall_mode)
			0: result_ready <= 1'b1;
			1: result_ready <= ($urandom_range(0, 3) != 0);
			2: result_ready <= ($urandom_range(0, 3) == 0);
			default: result_ready <= (stall_phase != 0);
		endcase
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && item_valid && item_ready) begin
			predicted_ticks.push_back(trim_tick(button_ticks.pop_front()));
			item_sent = 1'b1;
		end
		if (arst_n && result_valid && result_ready) begin
			if (predicted_ticks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result transfer with nothing predicted: trim=%0d", result.trim_value);
			end else begin
				want = predicted_ticks.pop_front();
				if (result.toggle_one !== want.toggle_one
					|| result.toggle_two !== want.toggle_two
					|| result.toggle_both !== want.toggle_both
					|| result.trim_value !== want.trim_value
					|| result.auto_repeat_on !== want.auto_repeat_on) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at %0t: expected t1=%0b t2=%0b both=%0b trim=%0d ",
							"auto=%0b, got t1=%0b t2=%0b both=%0b trim=%0d auto=%0b"},
							$realtime, want.toggle_one, want.toggle_two, want.toggle_both,
							want.trim_value, want.auto_repeat_on, result.toggle_one,
							result.toggle_two, result.toggle_both, result.trim_value,
							result.auto_repeat_on);
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// toggles and manual steps at reset settings, chords pressed together and in turn
		push_tick(1'b1, 1'b0, 2);
		push_tick(1'b0, 1'b0, 1);
		push_tick(1'b0, 1'b1, 1);
		push_tick(1'b1, 1'b1, 2);
		push_tick(1'b0, 1'b1, 1);
		push_tick(1'b1, 1'b1, 1);
		push_tick(1'b0, 1'b0, 1);
		push_tick(1'b1, 1'b1, 1);
		run_ticks();

		// short delay: enter auto-repeat, leave it, start a new hold
		write_reg(REG_HOLD_DELAY, CFG_DATA_BITS'(2));
		write_reg(REG_REPEAT_PERIOD, CFG_DATA_BITS'(0));
		write_reg(REG_UNUSED, CFG_DATA_BITS'(5));
		push_tick(1'b1, 1'b0, 5);
		push_tick(1'b0, 1'b0, 1);
		push_tick(1'b0, 1'b1, 2);
		run_ticks();

		// delay lowered below the running hold count fires on the next tick
		write_reg(REG_HOLD_DELAY, CFG_DATA_BITS'(0));
		push_tick(1'b0, 1'b1, 2);
		push_tick(1'b0, 1'b0, 1);
		run_ticks();

		// clamp extremes, minimum above maximum first
		write_reg(REG_HOLD_DELAY, '1);
		write_reg(REG_REPEAT_PERIOD, '1);
		write_reg(REG_TRIM_MAX, {1'b1, {(TRIM_BITS-1){1'b0}}});
		write_reg(REG_TRIM_MIN, {1'b0, {(TRIM_BITS-1){1'b1}}});
		push_tick(1'b0, 1'b0, 1);
		run_ticks();
		write_reg(REG_TRIM_MIN, {1'b1, {(TRIM_BITS-1){1'b0}}});
		write_reg(REG_TRIM_MAX, {1'b0, {(TRIM_BITS-1){1'b1}}});
		push_tick(1'b0, 1'b1, 1);
		run_ticks();
		write_reg(REG_TRIM_MAX, {1'b1, {(TRIM_BITS-1){1'b0}}});
		push_tick(1'b0, 1'b0, 1);
		run_ticks();
		write_reg(REG_TRIM_MAX, {1'b0, {(TRIM_BITS-1){1'b1}}});
		push_tick(1'b1, 1'b0, 1);
		run_ticks();

		for (int p = 0; p < 12; p++) begin
			shuffle_settings();
			queue_random_ticks(140);
			run_ticks();
		end

		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (mismatches == 0 && predicted_ticks.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/btc_pkg.sv
rtl/core/btc_cfg.sv
rtl/core/btc_step.sv
rtl/core/button_toggle_trim_counter.sv
dv/tb_button_toggle_trim_counter.sv
